// ===== sv/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg
// Types, codes and widths shared by the polygon scanline cell fill block.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int XW  = 32;  // coordinate width
  localparam int CXW = 46;  // cell center width before saturation
  localparam int MW  = 33;  // multiplier operand / divisor width
  localparam int PW  = 66;  // product / dividend width
  localparam int QW  = 34;  // quotient width
  localparam int RCW = 12;  // row / column width
  localparam int DW  = 16;  // grid dimension width

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CXM, S_CXW, S_CYM, S_CYW, S_GWD, S_GWW, S_GHD, S_GHW,
    S_BOUND, S_RD, S_CHK, S_MAG, S_MULW, S_DIVW, S_CMP, S_DONE
  } state_t;

  typedef struct packed {
    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic signed [XW-1:0] ex;
    logic signed [XW-1:0] ey;
  } edge_t;

endpackage

// ===== sv/polygon_scanline_cell_fill.sv =====
// ----------------------------------------------------------------------------
// polygon_scanline_cell_fill
// Even-odd polygon fill test of one grid cell against a stored edge list.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready) carry an operation: load an edge, clear the
// edge list, or query one cell. Load and clear return no word; a load into a
// full list returns one word with status 3. A query returns one word on
// out_valid/out_ready with the cell center, grid size, inside flag and status.
// A query on a non-empty list runs setup (two center multiplies and two
// grid-size divides on the shared multiplier and divider) and, if the center
// lies below the box maximum on both axes, walks the stored edges: an edge that
// misses the center line is only read and checked, and one that crosses it
// also waits on the multiplier and on the one-bit-per-cycle divider.
// in_ready is high only while no query is in progress. A load or clear is
// still taken while a finished result waits for out_ready; a further result
// holds in the block until the output register frees.
// Reset empties the edge list, resets the box and sets grid_step to 1.0.
// grid_step is written through cfg_we/cfg_wdata; the user must write it only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module polygon_scanline_cell_fill #(
  parameter int MAX_EDGES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [30:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             operation,
  input  logic signed [31:0]     start_x,
  input  logic signed [31:0]     start_y,
  input  logic signed [31:0]     end_x,
  input  logic signed [31:0]     end_y,
  input  logic [11:0]            cell_row,
  input  logic [11:0]            cell_col,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   inside_res,
  output logic signed [31:0]     center_x,
  output logic signed [31:0]     center_y,
  output logic [15:0]            grid_width,
  output logic [15:0]            grid_height,
  output logic [1:0]             status
);
  import psf_pkg::*;

  localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNTW = $clog2(MAX_EDGES + 1);

  localparam logic signed [XW-1:0] CMAX = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0] CMIN = {1'b1, {(XW-1){1'b0}}};

  function automatic logic signed [CXW-1:0] sx_c(input logic [XW-1:0] v);
    return $signed({{(CXW-XW){v[XW-1]}}, v});
  endfunction

  function automatic logic signed [MW-1:0] sx_m(input logic [XW-1:0] v);
    return $signed({v[XW-1], v});
  endfunction

  function automatic logic [MW-1:0] mag46(input logic signed [CXW-1:0] v);
    logic signed [CXW-1:0] t;
    t = v[CXW-1] ? -v : v;
    return t[MW-1:0];
  endfunction

  function automatic logic [MW-1:0] mag33(input logic signed [MW-1:0] v);
    return v[MW-1] ? MW'(-v) : v;
  endfunction

  function automatic logic [XW-1:0] sat32(input logic signed [CXW-1:0] v);
    if (v > sx_c(CMAX)) return CMAX;
    if (v < sx_c(CMIN)) return CMIN;
    return v[XW-1:0];
  endfunction

  function automatic logic [DW-1:0] dim(input logic [QW-1:0] q);
    if (q > QW'(65533)) return {DW{1'b1}};
    return q[DW-1:0] + DW'(2);
  endfunction

  function automatic logic signed [XW-1:0] smin(input logic signed [XW-1:0] a,
                                                input logic signed [XW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [XW-1:0] smax(input logic signed [XW-1:0] a,
                                                input logic signed [XW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  state_t state, state_next;

  logic [30:0]           grid_step;
  logic [30:0]           step_eff;
  logic [CNTW-1:0]       edge_count, k, k_inc;
  logic signed [XW-1:0]  box_min_x, box_min_y, box_max_x, box_max_y;
  edge_t                 mem [MAX_EDGES];
  edge_t                 rdata, wedge;
  logic                  accept, full, last, oob, chk_skip;
  logic [RCW-1:0]        row_r, col_r;
  logic signed [CXW-1:0] cx, cy, a_d, ix;
  logic signed [MW-1:0]  b_d, d_d;
  logic [MW-1:0]         dmag;
  logic                  neg;
  logic signed [XW-1:0]  ex_r;
  logic                  tot_odd, tot_nz, left_odd;
  logic [XW-1:0]         res_cx, res_cy;
  logic [DW-1:0]         res_gw, res_gh;
  status_t               res_status;
  logic [MW-1:0]         span_x, span_y;

  logic                  mul_start, mul_done, div_start, div_done;
  logic [MW-1:0]         mul_a, mul_b, div_d;
  logic [PW-1:0]         mul_p, div_n;
  logic [QW-1:0]         div_q;

  assign step_eff = (grid_step == '0) ? 31'd1 : grid_step;
  assign accept   = in_valid && in_ready;
  assign full     = (edge_count == CNTW'(MAX_EDGES));
  assign k_inc    = k + 1'b1;
  assign last     = (k_inc == edge_count);
  assign oob      = (cx >= sx_c(box_max_x)) || (cy >= sx_c(box_max_y));
  assign span_x   = sx_m(box_max_x) - sx_m(box_min_x);
  assign span_y   = sx_m(box_max_y) - sx_m(box_min_y);
  assign wedge    = '{sx: start_x, sy: start_y, ex: end_x, ey: end_y};
  assign chk_skip = (rdata.sy == rdata.ey)
                 || (cy < sx_c(smin(rdata.sy, rdata.ey)))
                 || (cy > sx_c(smax(rdata.sy, rdata.ey)));
  assign ix = neg ? sx_c(ex_r) + $signed({{(CXW-QW){1'b0}}, div_q})
                  : sx_c(ex_r) - $signed({{(CXW-QW){1'b0}}, div_q});

  // edge list: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && operation == OP_LOAD && !full) mem[edge_count[AW-1:0]] <= wedge;
    rdata <= mem[k[AW-1:0]];
  end

  psf_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  psf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OP_LOAD && full) state_next = S_DONE;
          else if (operation == OP_QUERY)
            state_next = (edge_count == '0) ? S_DONE : S_CXM;
        end
      end
      S_CXM:   state_next = S_CXW;
      S_CXW:   if (mul_done) state_next = S_CYM;
      S_CYM:   state_next = S_CYW;
      S_CYW:   if (mul_done) state_next = S_GWD;
      S_GWD:   state_next = S_GWW;
      S_GWW:   if (div_done) state_next = S_GHD;
      S_GHD:   state_next = S_GHW;
      S_GHW:   if (div_done) state_next = S_BOUND;
      S_BOUND: state_next = oob ? S_DONE : S_RD;
      S_RD:    state_next = S_CHK;
      S_CHK:   state_next = chk_skip ? (last ? S_DONE : S_RD) : S_MAG;
      S_MAG:   state_next = S_MULW;
      S_MULW:  if (mul_done) state_next = S_DIVW;
      S_DIVW:  if (div_done) state_next = S_CMP;
      S_CMP:   state_next = last ? S_DONE : S_RD;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    mul_start = 1'b0;
    mul_a     = mag46(a_d);
    mul_b     = mag33(b_d);
    div_start = 1'b0;
    div_n     = mul_p;
    div_d     = dmag;
    case (state)
      S_CXM: begin
        mul_start = 1'b1;
        mul_a     = {{(MW-RCW){1'b0}}, col_r};
        mul_b     = {2'b00, step_eff};
      end
      S_CYM: begin
        mul_start = 1'b1;
        mul_a     = {{(MW-RCW){1'b0}}, row_r};
        mul_b     = {2'b00, step_eff};
      end
      S_GWD: begin
        div_start = 1'b1;
        div_n     = {{(PW-MW){1'b0}}, span_x};
        div_d     = {2'b00, step_eff};
      end
      S_GHD: begin
        div_start = 1'b1;
        div_n     = {{(PW-MW){1'b0}}, span_y};
        div_d     = {2'b00, step_eff};
      end
      S_MAG:  mul_start = 1'b1;
      S_MULW: div_start = mul_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      grid_step  <= 31'd65536;
      edge_count <= '0;
      box_min_x  <= CMAX;
      box_min_y  <= CMAX;
      box_max_x  <= CMIN;
      box_max_y  <= CMIN;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) grid_step <= cfg_wdata;
      // a new word loaded in S_DONE keeps the output valid
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_cx     <= '0;
            res_cy     <= '0;
            res_gw     <= '0;
            res_gh     <= '0;
            row_r      <= cell_row;
            col_r      <= cell_col;
            tot_odd    <= 1'b0;
            tot_nz     <= 1'b0;
            left_odd   <= 1'b0;
            k          <= '0;
            case (operation)
              OP_LOAD: begin
                if (full) res_status <= ST_FULL;
                else begin
                  edge_count <= edge_count + 1'b1;
                  box_min_x  <= smin(box_min_x, smin(start_x, end_x));
                  box_min_y  <= smin(box_min_y, smin(start_y, end_y));
                  box_max_x  <= smax(box_max_x, smax(start_x, end_x));
                  box_max_y  <= smax(box_max_y, smax(start_y, end_y));
                end
              end
              OP_CLEAR: begin
                edge_count <= '0;
                box_min_x  <= CMAX;
                box_min_y  <= CMAX;
                box_max_x  <= CMIN;
                box_max_y  <= CMIN;
              end
              OP_QUERY: res_status <= (edge_count == '0) ? ST_EMPTY : ST_OK;
              default: ;
            endcase
          end
        end
        S_CXW: if (mul_done)
          cx <= sx_c(box_min_x) + $signed({3'b000, mul_p[42:0]})
              + $signed({{(CXW-30){1'b0}}, step_eff[30:1]});
        S_CYW: if (mul_done)
          cy <= sx_c(box_min_y) + $signed({3'b000, mul_p[42:0]})
              + $signed({{(CXW-30){1'b0}}, step_eff[30:1]});
        S_GWW: if (div_done) res_gw <= dim(div_q);
        S_GHW: if (div_done) res_gh <= dim(div_q);
        S_BOUND: begin
          res_cx <= sat32(cx);
          res_cy <= sat32(cy);
          if (oob) res_status <= ST_BOUNDS;
        end
        S_CHK: begin
          a_d  <= sx_c(rdata.ey) - cy;
          b_d  <= sx_m(rdata.ex) - sx_m(rdata.sx);
          d_d  <= sx_m(rdata.ey) - sx_m(rdata.sy);
          ex_r <= rdata.ex;
          if (chk_skip) k <= k_inc;
          else begin
            tot_odd <= !tot_odd;
            tot_nz  <= 1'b1;
          end
        end
        S_MAG: begin
          dmag <= mag33(d_d);
          neg  <= a_d[CXW-1] ^ b_d[MW-1] ^ d_d[MW-1];
        end
        S_CMP: begin
          if (ix < cx) left_odd <= !left_odd;
          k <= k_inc;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            inside_res  <= (res_status == ST_OK) && tot_nz && !tot_odd && left_odd;
            center_x    <= res_cx;
            center_y    <= res_cy;
            grid_width  <= res_gw;
            grid_height <= res_gh;
            status      <= res_status;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    edge_count <= CNTW'(MAX_EDGES))
    else $error("edge count past capacity");

  a_walk_in_list: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> k < edge_count)
    else $error("edge walk past stored edges");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_CXW || state == S_CYW || state == S_MULW))
    else $error("multiplier finished outside a wait state");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_GWW || state == S_GHW || state == S_DIVW))
    else $error("divider finished outside a wait state");

  a_bounds_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !inside_res)
    else $error("inside flag set on a failed query");
`endif

endmodule

// ===== sv/psf_mul.sv =====
// ----------------------------------------------------------------------------
// psf_mul
// Multi-cycle unsigned 33x33 multiplier built from four 17x17 partial products.
// ----------------------------------------------------------------------------
module psf_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [psf_pkg::MW-1:0] a,
  input  logic [psf_pkg::MW-1:0] b,
  output logic                  done,
  output logic [psf_pkg::PW-1:0] p
);
  import psf_pkg::*;

  localparam int HW = 17;

  logic [MW-1:0]   a_r, b_r;
  logic [2:0]      idx;
  logic            run, pp_vld;
  logic [2*HW-1:0] pp;
  logic [1:0]      pp_sh;
  logic [HW-1:0]   a_part, b_part;
  logic [PW-1:0]   pp_ext;

  always_comb begin
    a_part = (idx == 3'd2 || idx == 3'd3) ? {1'b0, a_r[MW-1:HW]} : a_r[HW-1:0];
    b_part = (idx == 3'd1 || idx == 3'd3) ? {1'b0, b_r[MW-1:HW]} : b_r[HW-1:0];
    case (pp_sh)
      2'd0:    pp_ext = {{(PW-2*HW){1'b0}}, pp};
      2'd1:    pp_ext = {{(PW-2*HW-HW){1'b0}}, pp, {HW{1'b0}}};
      // high x high fits in 32 bits
      default: pp_ext = {pp[PW-2*HW-1:0], {(2*HW){1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
      idx    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        idx    <= '0;
        run    <= 1'b1;
        pp_vld <= 1'b0;
        p      <= '0;
      end else if (run) begin
        if (idx != 3'd4) begin
          pp     <= a_part * b_part;
          pp_sh  <= (idx == 3'd0) ? 2'd0 : (idx == 3'd3) ? 2'd2 : 2'd1;
          pp_vld <= 1'b1;
          idx    <= idx + 3'd1;
        end else begin
          pp_vld <= 1'b0;
          run    <= 1'b0;
          done   <= 1'b1;
        end
        if (pp_vld) p <= p + pp_ext;
      end
    end
  end

endmodule

// ===== sv/psf_div.sv =====
// ----------------------------------------------------------------------------
// psf_div
// Restoring divider, one quotient bit per cycle, 34 quotient bits. The upper
// 32 dividend bits must be below the divisor.
// ----------------------------------------------------------------------------
module psf_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [psf_pkg::PW-1:0] dividend,
  input  logic [psf_pkg::MW-1:0] divisor,
  output logic                  done,
  output logic [psf_pkg::QW-1:0] quo
);
  import psf_pkg::*;

  logic [MW-1:0] d_r, rem;
  logic [5:0]    cnt;
  logic          run;
  logic [MW:0]   r2, diff;

  always_comb begin
    r2   = {rem, quo[QW-1]};
    diff = r2 - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        d_r <= divisor;
        rem <= {1'b0, dividend[PW-1:QW]};
        quo <= dividend[QW-1:0];
        cnt <= 6'(QW);
        run <= 1'b1;
      end else if (run) begin
        if (!diff[MW]) begin
          rem <= diff[MW-1:0];
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= r2[MW-1:0];
          quo <= {quo[QW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
